FILE: src/flfd_pkg.sv
`default_nettype none

package flfd_pkg;

  // Depth of the delay store when the top level is not told otherwise.
  localparam int MAX_DELAY_DEF = 2048;

  // Sine table geometry. The depth must be a power of two, at least 16.
  localparam int SINE_TABLE_DEPTH = 1024;
  localparam int SINE_IDX_W       = $clog2(SINE_TABLE_DEPTH);
  localparam int SINE_QUARTER     = SINE_TABLE_DEPTH / 4;
  localparam int SINE_K_W         = SINE_IDX_W - 1;

  // Depth of the queues between the parts of the block.
  localparam int QUEUE_DEPTH = 2;

  // Field and register widths.
  localparam int SAMPLE_W   = 16;
  localparam int FRAC_W     = 16;
  localparam int PHASE_W    = 32;
  localparam int DL_W       = 12;
  localparam int GAIN_W     = 16;
  localparam int STEP_W     = 31;
  localparam int SPS_W      = 18;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 31;

  // Register values after reset.
  localparam logic [DL_W-1:0]   DELAY_LENGTH_RST       = 12'd512;
  localparam logic [GAIN_W-1:0] EXCURSION_RST          = 16'd16384;
  localparam logic [GAIN_W-1:0] MIX_GAIN_RST           = 16'd16384;
  localparam logic [STEP_W-1:0] PHASE_STEP_RST         = 31'd44739;
  localparam logic [SPS_W-1:0]  SAMPLES_PER_SECOND_RST = 18'd48000;

  // Unity in Q1.15.
  localparam logic [GAIN_W-1:0] GAIN_ONE = 16'd32768;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DELAY_LENGTH       = 3'd0,
    CFG_EXCURSION          = 3'd1,
    CFG_MIX_GAIN           = 3'd2,
    CFG_PHASE_STEP         = 3'd3,
    CFG_SAMPLES_PER_SECOND = 3'd4
  } cfg_idx_e;

  // Front sequencer: oscillator, sine lookup and delay computation.
  typedef enum logic [2:0] {
    F_IDLE,
    F_SINE,
    F_SCALE,
    F_DELAY,
    F_PUSH
  } front_state_e;

  // Back sequencer: delay store access, interpolation and mixing.
  typedef enum logic [2:0] {
    B_CLEAR,
    B_IDLE,
    B_WRITE,
    B_READ_I,
    B_READ_J,
    B_INTERP,
    B_WET,
    B_OUT
  } back_state_e;

  // Magnitude of the sine for the first quadrant, entry k of SINE_QUARTER + 1.
  // Horner evaluation of the Taylor series to the eleventh power in Q30,
  // rounded half up to Q15 and limited to 32767.
  function automatic logic [SAMPLE_W-1:0] sine_mag(input int unsigned k);
    longint unsigned f;
    longint unsigned a;
    longint unsigned a2;
    longint unsigned term;
    longint unsigned s;
    longint unsigned q;
    f    = 64'(k) << (32 - SINE_IDX_W);
    a    = (f * 64'd1686629713) >> 30;
    a2   = (a * a) >> 30;
    term = 64'd1073741824 - ((a2 * 64'd1073741824) >> 30) / 64'd110;
    term = 64'd1073741824 - ((a2 * term) >> 30) / 64'd72;
    term = 64'd1073741824 - ((a2 * term) >> 30) / 64'd42;
    term = 64'd1073741824 - ((a2 * term) >> 30) / 64'd20;
    term = 64'd1073741824 - ((a2 * term) >> 30) / 64'd6;
    s    = (a * term) >> 30;
    q    = (s + 64'd16384) >> 15;
    if (q > 64'd32767) begin
      q = 64'd32767;
    end
    return q[SAMPLE_W-1:0];
  endfunction

endpackage

`default_nettype wire

FILE: src/flanger_fractional_delay.sv
// Flow: the front steps through F_SINE, F_SCALE, F_DELAY and F_PUSH, the middle queue
// holds its results, and the back steps through B_WRITE, B_READ_I, B_READ_J, B_INTERP,
// B_WET and B_OUT before the result queue. The back sets the pace: it writes the sample
// and then reads the two neighbors through the single read port of the delay RAM; the
// front runs ahead by up to three samples. Reset is asynchronous, active low; after it,
// full stays high while the delay RAM is cleared one entry per cycle.
`default_nettype none

module flanger_fractional_delay import flfd_pkg::*; #(
  parameter int MAX_DELAY = MAX_DELAY_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  wire logic                  push,
  output logic                       full,
  input  wire logic [SAMPLE_W-1:0]   in_sample_i,
  output logic                       empty,
  input  wire logic                  pop,
  output logic [SAMPLE_W-1:0]        out_sample_o
);

  localparam int ADDR_W  = $clog2(MAX_DELAY);
  localparam int LEN_W   = $clog2(MAX_DELAY + 1);
  localparam int ENTRY_W = SAMPLE_W + 2*ADDR_W + FRAC_W;
  localparam int CMP_W   = (LEN_W > DL_W) ? LEN_W : DL_W;

  logic [DL_W-1:0]   delay_length_q;
  logic [GAIN_W-1:0] excursion_q;
  logic [GAIN_W-1:0] mix_gain_q;
  logic [STEP_W-1:0] phase_step_q;
  logic [SPS_W-1:0]  sps_q;

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_length_q <= DELAY_LENGTH_RST;
      excursion_q    <= EXCURSION_RST;
      mix_gain_q     <= MIX_GAIN_RST;
      phase_step_q   <= PHASE_STEP_RST;
      sps_q          <= SAMPLES_PER_SECOND_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_DELAY_LENGTH:       delay_length_q <= cfg_wdata_i[DL_W-1:0];
        CFG_EXCURSION:          excursion_q    <= cfg_wdata_i[GAIN_W-1:0];
        CFG_MIX_GAIN:           mix_gain_q     <= cfg_wdata_i[GAIN_W-1:0];
        CFG_PHASE_STEP:         phase_step_q   <= cfg_wdata_i[STEP_W-1:0];
        CFG_SAMPLES_PER_SECOND: sps_q          <= cfg_wdata_i[SPS_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective circular length, limited to 2..MAX_DELAY.
  logic [CMP_W-1:0] dl_ext;
  logic [LEN_W-1:0] len;
  assign dl_ext = CMP_W'(delay_length_q);
  always_comb begin
    if (dl_ext < CMP_W'(2)) begin
      len = LEN_W'(2);
    end else if (dl_ext > CMP_W'(MAX_DELAY)) begin
      len = LEN_W'(MAX_DELAY);
    end else begin
      len = LEN_W'(dl_ext);
    end
  end

  logic               clear_busy;
  logic               mid_full, mid_empty, mid_push, mid_pop;
  logic [ENTRY_W-1:0] mid_wdata, mid_rdata;
  logic               out_full, out_push;
  logic [SAMPLE_W-1:0] out_wdata;

  flfd_front #(
    .MAX_DELAY (MAX_DELAY)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .in_sample_i  (in_sample_i),
    .full_o       (full),
    .hold_i       (clear_busy),
    .len_i        (len),
    .excursion_i  (excursion_q),
    .phase_step_i (phase_step_q),
    .sps_i        (sps_q),
    .q_full_i     (mid_full),
    .q_push_o     (mid_push),
    .q_data_o     (mid_wdata)
  );

  // Queue between the front and the back.
  flfd_fifo #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_mid_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (mid_push),
    .data_i  (mid_wdata),
    .pop_i   (mid_pop),
    .data_o  (mid_rdata),
    .full_o  (mid_full),
    .empty_o (mid_empty)
  );

  flfd_back #(
    .MAX_DELAY (MAX_DELAY)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .len_i        (len),
    .mix_gain_i   (mix_gain_q),
    .q_empty_i    (mid_empty),
    .q_data_i     (mid_rdata),
    .q_pop_o      (mid_pop),
    .out_full_i   (out_full),
    .out_push_o   (out_push),
    .out_sample_o (out_wdata),
    .clear_busy_o (clear_busy)
  );

  // Result queue toward the consumer.
  flfd_fifo #(
    .WIDTH (SAMPLE_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_out_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (out_push),
    .data_i  (out_wdata),
    .pop_i   (pop),
    .data_o  (out_sample_o),
    .full_o  (out_full),
    .empty_o (empty)
  );

  // No sample reaches the back while the delay RAM is still being cleared.
  assert property (@(posedge clk_i) disable iff (!rst_ni) clear_busy |-> mid_empty)
    else $error("sample queued while the delay RAM was being cleared");

endmodule

`default_nettype wire

FILE: src/flfd_ram.sv
`default_nettype none

module flfd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2048
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one read port with registered read data.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

FILE: src/flfd_fifo.sv
`default_nettype none

module flfd_fifo #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] data_i,
  input  wire logic             pop_i,
  output logic      [WIDTH-1:0] data_o,
  output logic                  full_o,
  output logic                  empty_o
);

  localparam int PTR_W = $clog2(DEPTH);

  logic [WIDTH-1:0] store_q [DEPTH];
  logic [PTR_W:0]   wr_ptr_q, wr_ptr_d;
  logic [PTR_W:0]   rd_ptr_q, rd_ptr_d;
  logic             do_push, do_pop;

  // A transaction happens only when the matching side allows it.
  assign full_o  = (wr_ptr_q[PTR_W] != rd_ptr_q[PTR_W]) &&
                   (wr_ptr_q[PTR_W-1:0] == rd_ptr_q[PTR_W-1:0]);
  assign empty_o = (wr_ptr_q == rd_ptr_q);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = store_q[rd_ptr_q[PTR_W-1:0]];

  assign wr_ptr_d = do_push ? wr_ptr_q + (PTR_W+1)'(1) : wr_ptr_q;
  assign rd_ptr_d = do_pop ? rd_ptr_q + (PTR_W+1)'(1) : rd_ptr_q;

  // Pointers carry one extra bit to tell full from empty.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      store_q[wr_ptr_q[PTR_W-1:0]] <= data_i;
    end
  end

endmodule

`default_nettype wire

FILE: src/flfd_front.sv
`default_nettype none

module flfd_front import flfd_pkg::*; #(
  parameter int MAX_DELAY = MAX_DELAY_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  push_i,
  input  wire logic [SAMPLE_W-1:0]   in_sample_i,
  output logic                       full_o,
  input  wire logic                  hold_i,
  input  wire logic [$clog2(MAX_DELAY+1)-1:0] len_i,
  input  wire logic [GAIN_W-1:0]     excursion_i,
  input  wire logic [STEP_W-1:0]     phase_step_i,
  input  wire logic [SPS_W-1:0]      sps_i,
  input  wire logic                  q_full_i,
  output logic                       q_push_o,
  output logic [SAMPLE_W+2*$clog2(MAX_DELAY)+FRAC_W-1:0] q_data_o
);

  localparam int ADDR_W = $clog2(MAX_DELAY);
  localparam int LEN_W  = $clog2(MAX_DELAY + 1);
  localparam int PROD_W = LEN_W + 31;
  localparam logic [PHASE_W-1:0] IDX_HALF = PHASE_W'(1) << (PHASE_W - 1 - SINE_IDX_W);

  front_state_e state_q, state_d;

  logic [ADDR_W-1:0]   wp_q, wp_d;
  logic [SPS_W-1:0]    count_q, count_d;
  logic [PHASE_W-1:0]  phase_q, phase_d;
  logic                accept;

  logic [SAMPLE_W-1:0]        x_q;
  logic [SINE_K_W-1:0]        kq_q;
  logic                       neg_q;
  logic signed [SAMPLE_W-1:0] sine_q;
  logic [30:0]                onep_q;
  logic [ADDR_W-1:0]          di_q;
  logic [FRAC_W-1:0]          frac_q;

  // Sine table: one quarter wave plus its end point.
  logic [SAMPLE_W-1:0] sine_rom [SINE_QUARTER+1];

  for (genvar k = 0; k <= SINE_QUARTER; k++) begin : g_rom
    assign sine_rom[k] = sine_mag(k);
  end

  assign accept = (state_q == F_IDLE) && push_i && !hold_i;

  // Next write pointer wraps at the effective length.
  logic [LEN_W-1:0] wp_inc;
  assign wp_inc = LEN_W'(wp_q) + LEN_W'(1);
  assign wp_d   = (wp_inc >= len_i) ? '0 : wp_inc[ADDR_W-1:0];

  // Oscillator count and phase restart together.
  logic [SPS_W:0] cnt_inc;
  logic           osc_wrap;
  assign cnt_inc  = {1'b0, count_q} + (SPS_W+1)'(1);
  assign osc_wrap = cnt_inc >= {1'b0, sps_i};
  assign count_d  = osc_wrap ? '0 : cnt_inc[SPS_W-1:0];
  assign phase_d  = osc_wrap ? '0 : phase_q + {1'b0, phase_step_i};

  // Nearest table entry, folded onto the quarter wave.
  logic [PHASE_W-1:0]    phase_rnd;
  logic [SINE_IDX_W-1:0] sidx;
  logic [SINE_K_W-1:0]   kq_d;
  assign phase_rnd = phase_q + IDX_HALF;
  assign sidx      = phase_rnd[PHASE_W-1 -: SINE_IDX_W];
  assign kq_d      = sidx[SINE_IDX_W-2] ?
                     SINE_K_W'(SINE_QUARTER) - SINE_K_W'(sidx[SINE_IDX_W-3:0]) :
                     SINE_K_W'(sidx[SINE_IDX_W-3:0]);

  // Delay factor 1 + excursion * sine in Q30; it never goes below zero.
  logic [GAIN_W-1:0]  exc_c;
  logic signed [32:0] exc_prod;
  logic signed [32:0] onep_sum;
  assign exc_c    = (excursion_i > GAIN_ONE) ? GAIN_ONE : excursion_i;
  assign exc_prod = $signed({1'b0, exc_c}) * sine_q;
  assign onep_sum = exc_prod + 33'sd1073741824;

  // Delay in Q.16: the integer part starts at bit 31 of the product.
  logic [LEN_W-1:0]  len_m1;
  logic [PROD_W-1:0] dly_prod;
  assign len_m1   = len_i - LEN_W'(1);
  assign dly_prod = PROD_W'(len_m1) * PROD_W'(onep_q);

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      wp_q    <= '0;
      count_q <= '0;
      phase_q <= '0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        wp_q    <= wp_d;
        count_q <= count_d;
        phase_q <= phase_d;
      end
    end
  end

  // Data path registers, one step per state.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      x_q   <= in_sample_i;
      kq_q  <= kq_d;
      neg_q <= sidx[SINE_IDX_W-1];
    end
    if (state_q == F_SINE) begin
      sine_q <= neg_q ? -$signed(sine_rom[kq_q]) : $signed(sine_rom[kq_q]);
    end
    if (state_q == F_SCALE) begin
      onep_q <= onep_sum[30:0];
    end
    if (state_q == F_DELAY) begin
      di_q   <= dly_prod[ADDR_W+30 -: ADDR_W];
      frac_q <= dly_prod[30:15];
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      F_IDLE:  if (accept) state_d = F_SINE;
      F_SINE:  state_d = F_SCALE;
      F_SCALE: state_d = F_DELAY;
      F_DELAY: state_d = F_PUSH;
      F_PUSH:  if (!q_full_i) state_d = F_IDLE;
      default: state_d = F_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    full_o   = (state_q != F_IDLE) || hold_i;
    q_push_o = (state_q == F_PUSH) && !q_full_i;
    q_data_o = {x_q, wp_q, di_q, frac_q};
  end

  // An accepted transaction keeps the input closed in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni) accept |=> full_o)
    else $error("front accepted a transaction but did not turn busy");

  // The oscillator only moves with an accepted sample.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   !accept |=> ($stable(phase_q) && $stable(count_q)))
    else $error("oscillator moved without a sample");

endmodule

`default_nettype wire

FILE: src/flfd_back.sv
`default_nettype none

module flfd_back import flfd_pkg::*; #(
  parameter int MAX_DELAY = MAX_DELAY_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic [$clog2(MAX_DELAY+1)-1:0] len_i,
  input  wire logic [GAIN_W-1:0]     mix_gain_i,
  input  wire logic                  q_empty_i,
  input  wire logic [SAMPLE_W+2*$clog2(MAX_DELAY)+FRAC_W-1:0] q_data_i,
  output logic                       q_pop_o,
  input  wire logic                  out_full_i,
  output logic                       out_push_o,
  output logic [SAMPLE_W-1:0]        out_sample_o,
  output logic                       clear_busy_o
);

  localparam int ADDR_W  = $clog2(MAX_DELAY);
  localparam int LEN_W   = $clog2(MAX_DELAY + 1);
  localparam int ENTRY_W = SAMPLE_W + 2*ADDR_W + FRAC_W;

  back_state_e state_q, state_d;

  logic [ADDR_W-1:0] clr_q;

  logic signed [SAMPLE_W-1:0] x_q;
  logic [ADDR_W-1:0]          wp_q;
  logic [ADDR_W-1:0]          di_q;
  logic [FRAC_W-1:0]          frac_q;
  logic [ADDR_W-1:0]          ai_q, aj_q;
  logic signed [SAMPLE_W-1:0] xi_q;
  logic signed [32:0]         dry_q;
  logic signed [34:0]         interp_q;
  logic signed [51:0]         wet_q;

  logic                ram_we;
  logic [ADDR_W-1:0]   ram_waddr;
  logic [SAMPLE_W-1:0] ram_wdata;
  logic [ADDR_W-1:0]   ram_raddr;
  logic [SAMPLE_W-1:0] ram_rdata;

  flfd_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (MAX_DELAY)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Queue entry layout: sample, write pointer, delay integer, delay fraction.
  logic take;
  assign take = (state_q == B_IDLE) && !q_empty_i;

  // Read addresses behind the write pointer, modulo the length.
  logic [LEN_W:0]   sum_i, sum_j;
  logic [LEN_W-1:0] dj_inc, dj;
  logic [ADDR_W-1:0] ai_d, aj_d;
  assign sum_i  = (LEN_W+1)'(wp_q) + (LEN_W+1)'(len_i) - (LEN_W+1)'(di_q);
  assign dj_inc = LEN_W'(di_q) + LEN_W'(1);
  assign dj     = (dj_inc >= len_i) ? '0 : dj_inc;
  assign sum_j  = (LEN_W+1)'(wp_q) + (LEN_W+1)'(len_i) - (LEN_W+1)'(dj);
  assign ai_d   = (sum_i >= (LEN_W+1)'(len_i)) ?
                  ADDR_W'(sum_i - (LEN_W+1)'(len_i)) : ADDR_W'(sum_i);
  assign aj_d   = (sum_j >= (LEN_W+1)'(len_i)) ?
                  ADDR_W'(sum_j - (LEN_W+1)'(len_i)) : ADDR_W'(sum_j);

  // Gains limited to one.
  logic [GAIN_W-1:0] mix_c, dry_gain;
  assign mix_c    = (mix_gain_i > GAIN_ONE) ? GAIN_ONE : mix_gain_i;
  assign dry_gain = GAIN_ONE - mix_c;

  // Linear interpolation between the two neighbors, Q.16.
  logic signed [16:0] diff;
  logic signed [33:0] fprod;
  logic signed [34:0] interp_d;
  assign diff     = $signed({ram_rdata[SAMPLE_W-1], ram_rdata}) -
                    $signed({xi_q[SAMPLE_W-1], xi_q});
  assign fprod    = $signed({1'b0, frac_q}) * diff;
  assign interp_d = $signed({{3{xi_q[SAMPLE_W-1]}}, xi_q, 16'h0000}) +
                    $signed({fprod[33], fprod});

  // Mix, round half up at bit 31 and saturate.
  logic signed [52:0] total;
  logic signed [21:0] y_full;
  logic [SAMPLE_W-1:0] y_sat;
  assign total  = $signed({{4{dry_q[32]}}, dry_q, 16'h0000}) +
                  $signed({wet_q[51], wet_q}) + 53'sd1073741824;
  assign y_full = total[52:31];
  always_comb begin
    if (y_full > 22'sd32767) begin
      y_sat = 16'h7fff;
    end else if (y_full < -22'sd32768) begin
      y_sat = 16'h8000;
    end else begin
      y_sat = y_full[SAMPLE_W-1:0];
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_CLEAR;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == B_CLEAR) begin
        clr_q <= clr_q + ADDR_W'(1);
      end
    end
  end

  // Data path registers.
  always_ff @(posedge clk_i) begin
    if (take) begin
      x_q    <= $signed(q_data_i[ENTRY_W-1 -: SAMPLE_W]);
      wp_q   <= q_data_i[FRAC_W+2*ADDR_W-1 -: ADDR_W];
      di_q   <= q_data_i[FRAC_W+ADDR_W-1 -: ADDR_W];
      frac_q <= q_data_i[FRAC_W-1:0];
    end
    if (state_q == B_WRITE) begin
      ai_q <= ai_d;
      aj_q <= aj_d;
    end
    if (state_q == B_READ_I) begin
      dry_q <= $signed({1'b0, dry_gain}) * x_q;
    end
    if (state_q == B_READ_J) begin
      xi_q <= $signed(ram_rdata);
    end
    if (state_q == B_INTERP) begin
      interp_q <= interp_d;
    end
    if (state_q == B_WET) begin
      wet_q <= $signed({1'b0, mix_c}) * interp_q;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      B_CLEAR:  if (clr_q == ADDR_W'(MAX_DELAY - 1)) state_d = B_IDLE;
      B_IDLE:   if (!q_empty_i) state_d = B_WRITE;
      B_WRITE:  state_d = B_READ_I;
      B_READ_I: state_d = B_READ_J;
      B_READ_J: state_d = B_INTERP;
      B_INTERP: state_d = B_WET;
      B_WET:    state_d = B_OUT;
      B_OUT:    if (!out_full_i) state_d = B_IDLE;
      default:  state_d = B_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    q_pop_o      = take;
    clear_busy_o = (state_q == B_CLEAR);
    ram_we       = (state_q == B_CLEAR) || (state_q == B_WRITE);
    ram_waddr    = (state_q == B_CLEAR) ? clr_q : wp_q;
    ram_wdata    = (state_q == B_CLEAR) ? '0 : x_q;
    ram_raddr    = (state_q == B_READ_J) ? aj_q : ai_q;
    out_push_o   = (state_q == B_OUT) && !out_full_i;
    out_sample_o = y_sat;
  end

  // Both read addresses stay inside the circular length.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (state_q == B_READ_I) |->
                   ((LEN_W'(ai_q) < len_i) && (LEN_W'(aj_q) < len_i)))
    else $error("delay read address outside the circular length");

  // The integer delay leaves room for its right neighbor.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (state_q == B_WRITE) |-> (dj_inc < len_i))
    else $error("integer delay reached the end of the store");

endmodule

`default_nettype wire

FILE: sim/tb.sv
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import flfd_pkg::*;

  localparam int CLK_PERIOD      = 8;
  localparam int RST_CYCLES      = 3;
  localparam int CYCLE_LIMIT     = 400000;
  localparam int DRAIN_CYCLES    = 32;
  localparam int RX_STALL_CYCLES = 400;
  localparam int BATCH_ITEMS     = 48;

  // Indexes past the last register; writes to them must change nothing.
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_UNUSED = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_LAST_IDX     = 3'd7;

  localparam longint Q30_ONE    = 64'sd1073741824;
  localparam longint HALF_ENTRY = 64'sd2147483648;

  // Ports of the block.
  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i   = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;
  logic                  push        = 1'b0;
  logic                  full;
  logic [SAMPLE_W-1:0]   in_sample_i = '0;
  logic                  empty;
  logic                  pop         = 1'b0;
  logic [SAMPLE_W-1:0]   out_sample_o;

  // Stimulus and scoreboard state.
  logic [SAMPLE_W-1:0] dry_queue [$];
  logic [SAMPLE_W-1:0] flanged_due [$];
  bit                  in_fire;
  bit                  out_fire;
  bit                  tx_hold       = 1'b0;
  int unsigned         send_idle_pct = 21;
  int unsigned         recv_idle_pct = 63;
  int unsigned         rx_stall_req  = 0;
  int unsigned         rx_stall_seen = 0;
  int unsigned         rx_stall_left = 0;
  int unsigned         fail_cnt      = 0;
  int unsigned         cycle_cnt     = 0;

  // Shadow of the register file.
  logic [DL_W-1:0]   dl_reg   = DELAY_LENGTH_RST;
  logic [GAIN_W-1:0] exc_reg  = EXCURSION_RST;
  logic [GAIN_W-1:0] mix_reg  = MIX_GAIN_RST;
  logic [STEP_W-1:0] step_reg = PHASE_STEP_RST;
  logic [SPS_W-1:0]  sps_reg  = SAMPLES_PER_SECOND_RST;

  // Shadow of the datapath state.
  logic signed [SAMPLE_W-1:0] sine_lut [SINE_TABLE_DEPTH];
  logic [SAMPLE_W-1:0]        store_shadow [MAX_DELAY_DEF];
  longint                     wp_shadow = 0;
  int unsigned                osc_count = 0;
  logic [PHASE_W-1:0]         osc_phase = '0;

  flanger_fractional_delay u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .push         (push),
    .full         (full),
    .in_sample_i  (in_sample_i),
    .empty        (empty),
    .pop          (pop),
    .out_sample_o (out_sample_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Table entry k holds sin(2*pi*k/depth) in Q1.15. The angle is folded into
  // the first quadrant and the Taylor series is evaluated in Q30 by Horner.
  function automatic logic signed [SAMPLE_W-1:0] sine_entry_q15(input int unsigned k);
    longint unsigned t;
    longint unsigned f;
    longint unsigned a;
    longint unsigned a2;
    longint unsigned term;
    longint unsigned s;
    longint unsigned q;
    t = (64'(k) << 32) / 64'(SINE_TABLE_DEPTH);
    f = t % 64'd1073741824;
    if (t[30]) begin
      f = 64'd1073741824 - f;
    end
    a    = (f * 64'd1686629713) >> 30;
    a2   = (a * a) >> 30;
    term = 64'd1073741824;
    for (int n = 5; n >= 1; n--) begin
      term = 64'd1073741824 - ((a2 * term) >> 30) / 64'((2 * n) * (2 * n + 1));
    end
    s = (a * term) >> 30;
    q = (s + 64'd16384) >> 15;
    if (q > 64'd32767) begin
      q = 64'd32767;
    end
    return t[31] ? -$signed(q[SAMPLE_W-1:0]) : $signed(q[SAMPLE_W-1:0]);
  endfunction

  // Stores one dry sample, advances the oscillator and returns the mixed output.
  function automatic logic [SAMPLE_W-1:0] flange_sample(input logic [SAMPLE_W-1:0] dry);
    longint x;
    longint len;
    longint exc;
    longint mix;
    longint sidx;
    longint onep;
    longint dq;
    longint di;
    longint dj;
    longint frac;
    longint xi;
    longint xj;
    longint interp;
    longint total;
    longint y;
    x   = longint'($signed(dry));
    len = longint'(dl_reg);
    if (len < 2) begin
      len = 2;
    end
    if (len > MAX_DELAY_DEF) begin
      len = MAX_DELAY_DEF;
    end
    exc = (exc_reg > GAIN_ONE) ? longint'(GAIN_ONE) : longint'(exc_reg);
    mix = (mix_reg > GAIN_ONE) ? longint'(GAIN_ONE) : longint'(mix_reg);

    wp_shadow = wp_shadow + 1;
    if (wp_shadow >= len) begin
      wp_shadow = 0;
    end
    store_shadow[wp_shadow] = dry;

    // Nearest table entry; the last half step of the circle wraps to entry zero.
    sidx = (longint'(osc_phase) * SINE_TABLE_DEPTH + HALF_ENTRY) >>> 32;
    if (sidx >= SINE_TABLE_DEPTH) begin
      sidx = 0;
    end
    onep = Q30_ONE + exc * longint'(sine_lut[sidx]);
    if (onep < 0) begin
      onep = 0;
    end
    dq = ((len - 1) * onep) >>> 15;

    // The oscillator restarts once its count reaches the programmed period.
    osc_count = osc_count + 1;
    osc_phase = osc_phase + PHASE_W'(step_reg);
    if (osc_count >= sps_reg) begin
      osc_count = 0;
      osc_phase = '0;
    end

    di   = dq >>> 16;
    frac = dq % 65536;
    if (di >= len) begin
      di = len - 1;
    end
    dj     = (di + 1) % len;
    xi     = longint'($signed(store_shadow[(wp_shadow + len - di) % len]));
    xj     = longint'($signed(store_shadow[(wp_shadow + len - dj) % len]));
    interp = xi * 65536 + frac * (xj - xi);
    total  = (32768 - mix) * x * 65536 + mix * interp;
    y      = (total + Q30_ONE) >>> 31;
    if (y > 32767) begin
      y = 32767;
    end
    if (y < -32768) begin
      y = -32768;
    end
    return y[SAMPLE_W-1:0];
  endfunction

  // Writes every register, then an unused index, and updates the shadow copy.
  // Called at a falling edge while the block is idle.
  task automatic set_regs(input logic [DL_W-1:0] dl, input logic [GAIN_W-1:0] exc,
                          input logic [GAIN_W-1:0] mix, input logic [STEP_W-1:0] step,
                          input logic [SPS_W-1:0] sps);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_DELAY_LENGTH;
    cfg_wdata_i <= CFG_DATA_W'(dl);
    @(negedge clk_i);
    cfg_idx_i   <= CFG_EXCURSION;
    cfg_wdata_i <= CFG_DATA_W'(exc);
    @(negedge clk_i);
    cfg_idx_i   <= CFG_MIX_GAIN;
    cfg_wdata_i <= CFG_DATA_W'(mix);
    @(negedge clk_i);
    cfg_idx_i   <= CFG_PHASE_STEP;
    cfg_wdata_i <= CFG_DATA_W'(step);
    @(negedge clk_i);
    cfg_idx_i   <= CFG_SAMPLES_PER_SECOND;
    cfg_wdata_i <= CFG_DATA_W'(sps);
    @(negedge clk_i);
    cfg_idx_i   <= CFG_IDX_W'($urandom_range(CFG_LAST_IDX, CFG_FIRST_UNUSED));
    cfg_wdata_i <= CFG_DATA_W'($urandom());
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
    dl_reg   = dl;
    exc_reg  = exc;
    mix_reg  = mix;
    step_reg = step;
    sps_reg  = sps;
  endtask

  // Queue updates happen at the rising edge, where only the monitor pops.
  task automatic send_directed(input logic [SAMPLE_W-1:0] s);
    @(posedge clk_i);
    dry_queue.push_back(s);
    @(negedge clk_i);
  endtask

  task automatic queue_batch(input int n);
    logic [SAMPLE_W-1:0] s;
    @(posedge clk_i);
    for (int k = 0; k < n; k++) begin
      case ($urandom_range(7))
        0: s = 16'h7FFF;
        1: s = 16'h8000;
        2: s = SAMPLE_W'($urandom_range(31)) - 16'd16;
        default: s = SAMPLE_W'($urandom());
      endcase
      dry_queue.push_back(s);
    end
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    while (dry_queue.size() != 0 || push || flanged_due.size() != 0) begin
      @(negedge clk_i);
    end
  endtask

  // Sender: keeps an offered sample until it is taken, otherwise may idle.
  always @(negedge clk_i) begin
    if (!push || in_fire) begin
      if (dry_queue.size() != 0 && !tx_hold && $urandom_range(99) >= send_idle_pct) begin
        push        <= 1'b1;
        in_sample_i <= dry_queue[0];
      end else begin
        push <= 1'b0;
      end
    end
  end

  // Receiver: random pops, plus a long hold-off whenever one is requested.
  always @(negedge clk_i) begin
    if (rx_stall_req != rx_stall_seen) begin
      rx_stall_seen = rx_stall_req;
      rx_stall_left = RX_STALL_CYCLES;
    end
    if (rx_stall_left != 0) begin
      rx_stall_left = rx_stall_left - 1;
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Monitor: predicts on each input transaction and checks each output transaction.
  always @(posedge clk_i) begin
    logic [SAMPLE_W-1:0] due;
    in_fire  = rst_ni && push && !full;
    out_fire = rst_ni && pop && !empty;
    if (in_fire) begin
      void'(dry_queue.pop_front());
      flanged_due.push_back(flange_sample(in_sample_i));
    end
    if (out_fire) begin
      if (flanged_due.size() == 0) begin
        $display("%0t: out_sample %0d arrived with nothing expected", $time,
                 $signed(out_sample_o));
        fail_cnt = fail_cnt + 1;
      end else begin
        due = flanged_due.pop_front();
        if (out_sample_o !== due) begin
          $display("%0t: out_sample mismatch, expected %0d, actual %0d", $time,
                   $signed(due), $signed(out_sample_o));
          fail_cnt = fail_cnt + 1;
        end
      end
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_cnt);
      $display("FAIL flanger_fractional_delay");
      $finish;
    end
  end

  initial begin
    logic [DL_W-1:0]   dl;
    logic [GAIN_W-1:0] exc;
    logic [GAIN_W-1:0] mix;
    logic [STEP_W-1:0] step;
    logic [SPS_W-1:0]  sps;

    for (int k = 0; k < SINE_TABLE_DEPTH; k++) begin
      sine_lut[k] = sine_entry_q15(k);
    end
    for (int k = 0; k < MAX_DELAY_DEF; k++) begin
      store_shadow[k] = '0;
    end

    repeat (RST_CYCLES) @(negedge clk_i);
    rst_ni = 1'b1;

    // Oversized delay length, dry path only: extremes and alternating bit patterns.
    set_regs(12'hFFF, GAIN_ONE, 16'd0, 31'h7FFF_FFFF, 18'd3);
    send_directed(16'h7FFF);
    send_directed(16'h8000);
    send_directed(16'h0000);
    send_directed(16'hFFFF);
    send_directed(16'h0001);
    send_directed(16'h5555);
    send_directed(16'hAAAA);
    send_directed(16'h7FFF);
    send_directed(16'h8000);
    wait_drained();

    // Zero length with the pointer far past it, gains above one, zero period.
    set_regs(12'd0, 16'hFFFF, 16'hFFFF, STEP_W'($urandom()), 18'd0);
    send_directed(16'h7FFF);
    send_directed(16'h8000);
    send_directed(16'h7FFF);
    send_directed(16'h8000);
    wait_drained();

    // Full length, no modulation, fully wet, longest period.
    set_regs(12'd2048, 16'd0, GAIN_ONE, 31'd0, 18'h3FFFF);
    send_directed(16'h8000);
    send_directed(16'h7FFF);
    send_directed(16'h1234);
    wait_drained();

    // Length one, eighth-turn steps, so the sine runs over the first half of the circle.
    set_regs(12'd1, GAIN_ONE, 16'd16384, 31'h2000_0000, 18'd200000);
    send_directed(16'h7FFF);
    send_directed(16'h8000);
    send_directed(16'h7FFF);
    send_directed(16'h8000);
    send_directed(16'h0000);
    wait_drained();

    // Random part in three idling regimes, each with several register settings.
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          send_idle_pct <= 21;
          recv_idle_pct <= 63;
        end
        1: begin
          send_idle_pct <= 63;
          recv_idle_pct <= 21;
        end
        default: begin
          send_idle_pct <= 0;
          recv_idle_pct <= 0;
        end
      endcase
      for (int sub = 0; sub < 3; sub++) begin
        case ($urandom_range(3))
          0: dl = DL_W'($urandom_range(8, 2));
          1: dl = DL_W'($urandom_range(64, 9));
          2: dl = DL_W'($urandom());
          default: dl = DL_W'(MAX_DELAY_DEF);
        endcase
        exc  = ($urandom_range(3) == 0) ? GAIN_W'($urandom()) : GAIN_W'($urandom_range(32768));
        mix  = ($urandom_range(3) == 0) ? GAIN_W'($urandom()) : GAIN_W'($urandom_range(32768));
        step = ($urandom_range(1) == 0) ? STEP_W'($urandom()) :
                                          STEP_W'($urandom_range(32'h0400_0000));
        sps  = ($urandom_range(3) == 0) ? SPS_W'($urandom()) : SPS_W'($urandom_range(64, 1));
        set_regs(dl, exc, mix, step, sps);
        queue_batch(BATCH_ITEMS);

        // Long receiver hold-off so the block fills up and pushes back.
        if (ph == 0 && sub == 1) begin
          rx_stall_req <= rx_stall_req + 1;
        end

        // Sender pause until every outstanding sample has come back.
        if (ph == 1 && sub == 1) begin
          while (dry_queue.size() > BATCH_ITEMS / 2) begin
            @(negedge clk_i);
          end
          tx_hold <= 1'b1;
          do begin
            @(negedge clk_i);
          end while (push || flanged_due.size() != 0);
          tx_hold <= 1'b0;
        end
        wait_drained();
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (flanged_due.size() != 0) begin
      $display("%0t: %0d expected samples never arrived", $time, flanged_due.size());
      fail_cnt = fail_cnt + 1;
    end
    if (fail_cnt == 0) begin
      $display("PASS flanger_fractional_delay");
    end else begin
      $display("FAIL flanger_fractional_delay");
    end
    $finish;
  end

endmodule

`default_nettype wire
